// File: src/lru_cache_with_expiry_unit_macros.svh
// ----------------------------------------------------------------------------
// lru cache with expiry: assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_WITH_EXPIRY_UNIT_MACROS_SVH
`define LRU_CACHE_WITH_EXPIRY_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LCX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcx assertion failed");

// next-cycle implication, disabled during reset
`define LCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcx assertion failed");

`endif

// File: src/lcx_pkg.sv
// ----------------------------------------------------------------------------
// lcx_pkg
// shared types and constants of the lru cache with expiry
// ----------------------------------------------------------------------------
package lcx_pkg;

    // payload widths
    localparam int KEY_W      = 64;
    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int AGE_W      = 16;
    localparam int ACT_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 4'd1;

    // configuration reset values
    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd300;
    localparam logic [ACT_W-1:0] ACTIVE_RESET  = 5'd16;

    // item modes
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_FILL   = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic start;
        logic rd_en;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

// File: src/lru_cache_with_expiry_unit.sv
// an item is accepted only in idle, so a new item waits until the previous result is committed
// the active entries (n = active entry count) are swept from the ram one entry per cycle
// a finished result waits in the output register while the next item is taken
// reset: synchronous active low; clears valid bits and restores max_age 300 and 16 entries
// ----------------------------------------------------------------------------
// lru_cache_with_expiry_unit
// fully associative name-to-address cache with age expiry and lru replacement
// ----------------------------------------------------------------------------
module lru_cache_with_expiry_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [lcx_pkg::KEY_W-1:0]      i_name_key,
    input  logic [lcx_pkg::TIME_W-1:0]     i_now_seconds,
    input  logic [lcx_pkg::ADDR_W-1:0]     i_fill_address,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_hit,
    output logic [lcx_pkg::ADDR_W-1:0]     o_found_address,
    output logic [lcx_pkg::SLOT_W-1:0]     o_slot,
    output logic                           o_stale,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lcx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcx_pkg::*;

    t_cmd                      cmd;
    t_status                   status;
    logic [$clog2(ENTRIES)-1:0] rd_idx;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // controller
    lcx_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    // datapath
    lcx_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_rd_idx        (rd_idx),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_name_key      (i_name_key),
        .i_now_seconds   (i_now_seconds),
        .i_fill_address  (i_fill_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_found_address (o_found_address),
        .o_slot          (o_slot),
        .o_stale         (o_stale)
    );

endmodule

// File: src/lcx_ram.sv
// ----------------------------------------------------------------------------
// lcx_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lcx_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lcx_ctrl.sv
// ----------------------------------------------------------------------------
// lcx_ctrl
// sequencer: accepts an item, sweeps the entries, then commits the result
// ----------------------------------------------------------------------------
module lcx_ctrl #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lcx_pkg::t_status           i_status,
    output lcx_pkg::t_cmd              o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_rd_idx
);
    import lcx_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (i_status.scan_last) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DECIDE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    // entry index counter
    always_comb begin
        n_idx = r_idx;
        if (o_cmd.start) begin
            n_idx = '0;
        end else if (o_cmd.rd_en) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_rd_idx = r_idx;

endmodule

// File: src/lcx_dp.sv
// ----------------------------------------------------------------------------
// lcx_dp
// datapath: entry stores, scan trackers, result logic and output register
// ----------------------------------------------------------------------------
module lcx_dp #(
    parameter int ENTRIES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lcx_pkg::t_cmd                      i_cmd,
    output lcx_pkg::t_status                   o_status,
    input  logic [$clog2(ENTRIES)-1:0]         i_rd_idx,
    input  logic                               i_cfg_valid,
    input  logic [lcx_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcx_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_mode,
    input  logic [lcx_pkg::KEY_W-1:0]          i_name_key,
    input  logic [lcx_pkg::TIME_W-1:0]         i_now_seconds,
    input  logic [lcx_pkg::ADDR_W-1:0]         i_fill_address,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_hit,
    output logic [lcx_pkg::ADDR_W-1:0]         o_found_address,
    output logic [lcx_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_stale
);
    import lcx_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    // configuration
    logic [AGE_W-1:0] r_max_age;
    logic [ACT_W-1:0] r_active;

    // latched item
    logic              r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_now;
    logic [ADDR_W-1:0] r_faddr;

    // entry valid bits
    logic [ENTRIES-1:0] r_valid;

    // ram read data
    logic [KEY_W-1:0]  rd_key;
    logic [ADDR_W-1:0] rd_addr;
    logic [TIME_W-1:0] rd_lu;

    // scan trackers
    logic              r_ev;
    logic [IDX_W-1:0]  r_ev_idx;
    logic              r_m_found;
    logic [IDX_W-1:0]  r_m_idx;
    logic [ADDR_W-1:0] r_m_addr;
    logic [TIME_W-1:0] r_m_lu;
    logic              r_e_found;
    logic [IDX_W-1:0]  r_e_idx;
    logic [TIME_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;

    // output register
    logic              r_out_valid;
    logic              r_hit;
    logic [ADDR_W-1:0] r_found;
    logic [IDX_W-1:0]  r_slot;
    logic              r_stale;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= MAX_AGE_RESET;
            r_active  <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_AGE: r_max_age <= i_cfg_data[AGE_W-1:0];
                CFG_ACTIVE:  r_active  <= i_cfg_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // active entry count, clamped to one .. ENTRIES
    logic [31:0] act_ext;
    logic [31:0] used_n;
    logic [31:0] last_ext;
    assign act_ext = 32'(r_active);
    always_comb begin
        if (act_ext == 32'd0) begin
            used_n = 32'd1;
        end else if (act_ext > 32'(ENTRIES)) begin
            used_n = 32'(ENTRIES);
        end else begin
            used_n = act_ext;
        end
    end
    assign last_ext = used_n - 32'd1;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_key   <= i_name_key;
            r_now   <= i_now_seconds;
            r_faddr <= i_fill_address;
        end
    end

    // decision logic
    logic [TIME_W-1:0] age_m;
    logic              is_stale;
    logic              dec_hit;
    logic              dec_stale;
    logic [IDX_W-1:0]  victim;
    logic [IDX_W-1:0]  wr_idx;
    logic              we_fill;
    logic              we_lu;

    assign age_m     = r_now - r_m_lu;
    assign is_stale  = age_m > TIME_W'(r_max_age);
    assign dec_hit   = (r_mode == MODE_LOOKUP) && r_m_found && !is_stale;
    assign dec_stale = (r_mode == MODE_LOOKUP) && r_m_found && is_stale;

    always_comb begin
        priority if (r_m_found) begin
            victim = r_m_idx;
        end else if (r_e_found) begin
            victim = r_e_idx;
        end else begin
            victim = r_best_idx;
        end
    end

    assign wr_idx  = (r_mode == MODE_FILL) ? victim : r_m_idx;
    assign we_fill = i_cmd.commit && (r_mode == MODE_FILL);
    assign we_lu   = we_fill || (i_cmd.commit && dec_hit);

    // entry stores
    lcx_ram #(.W(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we_fill),
        .i_waddr (wr_idx),
        .i_wdata (r_key),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_key)
    );

    lcx_ram #(.W(ADDR_W), .DEPTH(ENTRIES)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (we_fill),
        .i_waddr (wr_idx),
        .i_wdata (r_faddr),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_addr)
    );

    lcx_ram #(.W(TIME_W), .DEPTH(ENTRIES)) u_lu_ram (
        .i_clk   (i_clk),
        .i_we    (we_lu),
        .i_waddr (wr_idx),
        .i_wdata (r_now),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_lu)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we_fill) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    // read data is evaluated in the cycle after its address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else begin
            r_ev <= i_cmd.rd_en;
        end
        r_ev_idx <= i_rd_idx;
    end

    // scan evaluation: first match, first empty, oldest entry
    logic              ev_v;
    logic              ev_match;
    logic [TIME_W-1:0] ev_age;
    assign ev_v     = r_valid[r_ev_idx];
    assign ev_match = ev_v && (rd_key == r_key);
    assign ev_age   = r_now - rd_lu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_found <= 1'b0;
            r_e_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_m_found <= 1'b0;
            r_e_found <= 1'b0;
        end else if (r_ev) begin
            if (ev_match && !r_m_found) r_m_found <= 1'b1;
            if (!ev_v && !r_e_found) r_e_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best <= '0;
        end else if (r_ev) begin
            if (ev_match && !r_m_found) begin
                r_m_idx  <= r_ev_idx;
                r_m_addr <= rd_addr;
                r_m_lu   <= rd_lu;
            end
            if (!ev_v && !r_e_found) begin
                r_e_idx <= r_ev_idx;
            end
            if (ev_age >= r_best) begin
                r_best     <= ev_age;
                r_best_idx <= r_ev_idx;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit   <= dec_hit;
            r_stale <= dec_stale;
            r_found <= dec_hit ? r_m_addr : '0;
            if (r_mode == MODE_FILL) begin
                r_slot <= victim;
            end else begin
                r_slot <= r_m_found ? r_m_idx : '0;
            end
        end
    end

    // status
    logic [31:0] slot_ext;
    assign slot_ext = 32'(r_slot);

    assign o_status.scan_last = (32'(i_rd_idx) == last_ext);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_found_address = r_found;
    assign o_slot          = slot_ext[SLOT_W-1:0];
    assign o_stale         = r_stale;

endmodule

// File: src/lcx_checker.sv
// ----------------------------------------------------------------------------
// lcx_checker
// port-level assertions on the lru cache with expiry, bound to the top level
// ----------------------------------------------------------------------------
`include "lru_cache_with_expiry_unit_macros.svh"

module lcx_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_mode,
    input logic [lcx_pkg::KEY_W-1:0]      i_name_key,
    input logic [lcx_pkg::TIME_W-1:0]     i_now_seconds,
    input logic [lcx_pkg::ADDR_W-1:0]     i_fill_address,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_hit,
    input logic [lcx_pkg::ADDR_W-1:0]     o_found_address,
    input logic [lcx_pkg::SLOT_W-1:0]     o_slot,
    input logic                           o_stale,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [lcx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [lcx_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // a held result stays valid until taken
    `LCX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a result is never both a hit and a stale miss
    `LCX_ASSERT_SAME(a_hit_xor_stale, i_clk, i_rst_n, o_out_valid, !(o_hit && o_stale))

    // only a hit carries an address
    `LCX_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_hit, o_found_address == '0)

    // one item in flight: accepting an item drops ready on the next cycle
    `LCX_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind lru_cache_with_expiry_unit lcx_checker u_lcx_checker (.*);

// File: dv/tb_lru_cache_with_expiry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_cache_with_expiry_unit
// self-checking bench for the name-to-address cache: lookups and fills with
// random keys and clocks go in through valid/ready, a behavioral copy of the
// cache predicts every result, and results are compared field by field
// ----------------------------------------------------------------------------

// one result item of the cache
typedef struct packed {
    logic        hit;
    logic [31:0] addr;
    logic [3:0]  slot;
    logic        stale;
} cache_reply_t;

// behavioral cache plus the queue of replies it predicts
class cache_model #(int LINES = 16);
    logic [15:0]  max_age;
    logic [4:0]   active_cfg;
    bit           line_valid [LINES];
    logic [63:0]  line_key   [LINES];
    logic [31:0]  line_addr  [LINES];
    logic [31:0]  line_stamp [LINES];
    cache_reply_t expected_replies [$];
    int unsigned  mismatches;
    int unsigned  hits;
    int unsigned  stales;
    int unsigned  misses;
    int unsigned  fills;

    function new();
        max_age    = lcx_pkg::MAX_AGE_RESET;
        active_cfg = lcx_pkg::ACTIVE_RESET;
        foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_key[i]   = '0;
            line_addr[i]  = '0;
            line_stamp[i] = '0;
        end
        mismatches = 0;
        hits       = 0;
        stales     = 0;
        misses     = 0;
        fills      = 0;
    endfunction

    // unknown indexes are ignored
    function void write_reg(logic [3:0] idx, logic [15:0] data);
        if (idx == lcx_pkg::CFG_MAX_AGE) begin
            max_age = data;
        end else if (idx == lcx_pkg::CFG_ACTIVE) begin
            active_cfg = data[4:0];
        end
    endfunction

    // zero acts as one, above the line count acts as the line count
    function int unsigned lines_in_use();
        if (active_cfg == 0) return 1;
        if (active_cfg > LINES) return LINES;
        return 32'(active_cfg);
    endfunction

    // apply one accepted item and queue the reply it causes
    function void take_request(logic mode, logic [63:0] key, logic [31:0] now,
                               logic [31:0] addr);
        int unsigned  n;
        int           match;
        int unsigned  victim;
        logic [31:0]  age;
        logic [31:0]  oldest;
        bit           got_empty;
        cache_reply_t r;
        n     = lines_in_use();
        match = -1;
        r     = '0;
        for (int i = 0; i < n; i++) begin
            if (match < 0 && line_valid[i] && line_key[i] == key) match = i;
        end
        if (mode == lcx_pkg::MODE_LOOKUP) begin
            if (match >= 0) begin
                age    = now - line_stamp[match];
                r.slot = match[3:0];
                if (age > {16'd0, max_age}) begin
                    // expired match: reported, not refreshed
                    r.stale = 1'b1;
                    stales++;
                end else begin
                    r.hit             = 1'b1;
                    r.addr            = line_addr[match];
                    line_stamp[match] = now;
                    hits++;
                end
            end else begin
                misses++;
            end
        end else begin
            // victim: matching line, else first empty, else oldest (last on ties)
            victim    = 0;
            got_empty = 1'b0;
            if (match >= 0) begin
                victim = match;
            end else begin
                for (int i = 0; i < n; i++) begin
                    if (!got_empty && !line_valid[i]) begin
                        victim    = i;
                        got_empty = 1'b1;
                    end
                end
                if (!got_empty) begin
                    oldest = '0;
                    for (int i = 0; i < n; i++) begin
                        age = now - line_stamp[i];
                        if (age >= oldest) begin
                            oldest = age;
                            victim = i;
                        end
                    end
                end
            end
            line_valid[victim] = 1'b1;
            line_key[victim]   = key;
            line_addr[victim]  = addr;
            line_stamp[victim] = now;
            r.slot             = victim[3:0];
            fills++;
        end
        expected_replies.push_back(r);
    endfunction

    // compare one result item against the oldest prediction
    function void check_reply(cache_reply_t got);
        cache_reply_t want;
        if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: result with nothing pending: hit=%0b addr=%h slot=%0d stale=%0b",
                         got.hit, got.addr, got.slot, got.stale);
            end
            return;
        end
        want = expected_replies.pop_front();
        if (got.hit !== want.hit || got.addr !== want.addr ||
            got.slot !== want.slot || got.stale !== want.stale) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: expected hit=%0b addr=%h slot=%0d stale=%0b",
                         want.hit, want.addr, want.slot, want.stale);
                $display("       actual   hit=%0b addr=%h slot=%0d stale=%0b",
                         got.hit, got.addr, got.slot, got.stale);
            end
        end
    endfunction
endclass

module tb_lru_cache_with_expiry_unit;
    import lcx_pkg::*;

    localparam int          CACHE_LINES   = 16;
    localparam int          KEY_POOL      = 32;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 215;
    localparam int          SETTLE_CYCLES = CACHE_LINES + 8;
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    // an index outside the register map
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd7;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  i_mode          = MODE_LOOKUP;
    logic [KEY_W-1:0]      i_name_key      = '0;
    logic [TIME_W-1:0]     i_now_seconds   = '0;
    logic [ADDR_W-1:0]     i_fill_address  = '0;
    logic                  i_out_ready     = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_hit;
    logic [ADDR_W-1:0]     o_found_address;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_stale;
    logic                  o_cfg_ready;

    cache_model #(CACHE_LINES) model;
    logic [KEY_W-1:0]  key_pool [KEY_POOL];
    logic [TIME_W-1:0] wall_clock;
    bit                send_steady;
    bit                take_steady;
    int unsigned       items_sent;
    int unsigned       reg_writes;
    int unsigned       cycle_count;

    lru_cache_with_expiry_unit #(
        .ENTRIES(CACHE_LINES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_name_key     (i_name_key),
        .i_now_seconds  (i_now_seconds),
        .i_fill_address (i_fill_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_found_address(o_found_address),
        .o_slot         (o_slot),
        .o_stale        (o_stale),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // wait length for one item, with stretches of back-to-back traffic
    function automatic int unsigned draw_wait(ref bit steady);
        if ($urandom_range(0, 39) == 0) steady = !steady;
        if (steady) return 0;
        return $urandom_range(0, 12);
    endfunction

    // hand one item to the block, then idle for a random gap
    task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] now, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_name_key     <= key;
        i_now_seconds  <= now;
        i_fill_address <= addr;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        model.take_request(mode, key, now, addr);
        items_sent++;
        gap = draw_wait(send_steady);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted result has come back and the block is quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write through the config channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        model.write_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stalls, check every accepted result item
    initial begin
        int unsigned  stall;
        cache_reply_t got;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(take_steady);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got = '{o_hit, o_found_address, o_slot, o_stale};
            model.check_reply(got);
        end
    end

    // stimulus
    initial begin
        int unsigned           lim;
        int unsigned           span;
        int unsigned           pick;
        logic [4:0]            act_code;
        logic [AGE_W-1:0]      age_code;
        logic [CFG_DATA_W-1:0] cfg_word;
        logic [KEY_W-1:0]      key;
        logic                  mode;
        model       = new();
        items_sent  = 0;
        reg_writes  = 0;
        send_steady = 1'b0;
        take_steady = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty miss, age limit edge, stale, repair, wrapped age
        send_request(MODE_LOOKUP, key_pool[0], 32'd0, $urandom);
        send_request(MODE_FILL, key_pool[0], 32'd100, 32'h0000_0000);
        send_request(MODE_FILL, key_pool[1], 32'd100, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, key_pool[0], 32'd400, $urandom);
        send_request(MODE_LOOKUP, key_pool[1], 32'd401, $urandom);
        send_request(MODE_LOOKUP, key_pool[0], 32'd700, $urandom);
        send_request(MODE_FILL, key_pool[1], 32'd800, 32'h1234_5678);
        send_request(MODE_LOOKUP, key_pool[1], 32'd800, $urandom);
        send_request(MODE_LOOKUP, key_pool[0], 32'd50, $urandom);
        send_request(MODE_LOOKUP, key_pool[5], 32'd800, $urandom);
        wait_idle();

        // three lines, short age: empty slot, oldest victim, ties, future stamps
        write_reg(CFG_ACTIVE, 16'd3);
        write_reg(CFG_MAX_AGE, 16'd10);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_request(MODE_FILL, key_pool[2], 32'd1000, $urandom);
        send_request(MODE_FILL, key_pool[3], 32'd1000, $urandom);
        send_request(MODE_FILL, key_pool[4], 32'd1000, $urandom);
        send_request(MODE_FILL, key_pool[5], 32'd1000, $urandom);
        send_request(MODE_FILL, key_pool[6], 32'd999, $urandom);
        send_request(MODE_LOOKUP, key_pool[3], 32'd1010, $urandom);
        send_request(MODE_LOOKUP, key_pool[3], 32'd1021, $urandom);
        send_request(MODE_LOOKUP, key_pool[1], 32'd1021, $urandom);
        send_request(MODE_FILL, key_pool[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, key_pool[0], 32'd9, $urandom);
        wait_idle();

        // random phases, each under its own register settings
        wall_clock = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin age_code = 16'd0;                 act_code = 5'd16; end
                1: begin age_code = 16'hFFFF;              act_code = 5'd1;  end
                2: begin age_code = 16'd300;               act_code = 5'd31; end
                3: begin age_code = 16'($urandom_range(0, 2000)); act_code = 5'd0; end
                4: begin
                    age_code = 16'($urandom);
                    act_code = 5'($urandom_range(2, 15));
                end
                5: begin age_code = 16'($urandom_range(1, 1000)); act_code = 5'd17; end
                6: begin age_code = 16'd300;               act_code = 5'd16; end
                default: begin
                    age_code = 16'($urandom);
                    act_code = 5'($urandom_range(1, 16));
                end
            endcase
            // upper data bits of the line count write are don't-care
            cfg_word      = 16'($urandom);
            cfg_word[4:0] = act_code;
            write_reg(CFG_ACTIVE, cfg_word);
            write_reg(CFG_MAX_AGE, age_code);
            write_reg(CFG_SPARE, 16'($urandom));
            lim  = 32'(model.max_age);
            span = model.lines_in_use() + $urandom_range(0, 6);
            if (span > KEY_POOL) span = KEY_POOL;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // advance the clock: mostly fresh, sometimes just past expiry,
                // now and then a jump anywhere including backwards
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    wall_clock = wall_clock + $urandom_range(0, lim / 4);
                end else if (pick < 80) begin
                    wall_clock = wall_clock + $urandom_range(0, lim + 2);
                end else if (pick < 93) begin
                    wall_clock = wall_clock + lim + 1 + $urandom_range(0, 50);
                end else begin
                    wall_clock = $urandom;
                end
                if ($urandom_range(0, 99) < 92) begin
                    key = key_pool[$urandom_range(0, span - 1)];
                end else begin
                    key = {$urandom, $urandom};
                end
                mode = ($urandom_range(0, 99) < 45) ? MODE_FILL : MODE_LOOKUP;
                send_request(mode, key, wall_clock, $urandom);
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 199) == 0) wait_idle();
            end
            wait_idle();
        end

        wait_idle();
        if (model.expected_replies.size() != 0) begin
            $display("ERROR: %0d predicted results never arrived",
                     model.expected_replies.size());
            model.mismatches += model.expected_replies.size();
        end
        $display("covered %0d items and %0d register writes over %0d setting phases",
                 items_sent, reg_writes, PHASES + 2);
        $display("lookups: %0d hits, %0d stale, %0d misses; fills: %0d; mismatches: %0d",
                 model.hits, model.stales, model.misses, model.fills, model.mismatches);
        if (model.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
